// ===== rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, request and status codes, payload structs and the command
// format passed from the front end to the back end.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Storage sizes.
  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and response payloads.
  localparam int REQ_W     = 3;
  localparam int ELEM_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 9;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Request payload.
  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [ELEM_W-1:0] value;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } rsp_t;

  // Classified operation handed to the back end.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  at_back;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

  // Back end states.
  typedef enum logic {
    BK_EXEC,
    BK_READ
  } back_state_t;

  // Sign extend (or truncate) a stored word into the response element field.
  function automatic logic signed [ELEM_W-1:0] widen(input logic [DATA_WIDTH-1:0] d);
    logic signed [DATA_WIDTH-1:0] s;
    s = d;
    return ELEM_W'(s);
  endfunction

endpackage

// ===== rtl/double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Bounded deque of signed words on a ring buffer: push, pop and peek at
// either end, and clear; one response per request.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------
//   request | req_valid, req_ready | req: req_type, value
//   response| rsp_valid, rsp_ready | rsp: element, status, count, is_empty
//
// In the back end a push, a clear or an error completes in BK_EXEC, and a
// pop or peek also waits in BK_READ for the registered slot memory read.
// A request reaches the back end through the command register and a
// two-entry command queue, so the front end keeps taking requests while
// the response waits. Reset (rst, synchronous) empties the deque; slot
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_top import deq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  req_t  req,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  output rsp_t  rsp
);

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic bk_valid;
  logic bk_ready;
  cmd_t bk_cmd;

  // Request decode.
  deq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  // Command queue between decode and execution.
  deq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_cmd   (fr_cmd),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_cmd   (bk_cmd)
  );

  // Execution on the ring buffer.
  deq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (bk_valid),
    .cmd_ready (bk_ready),
    .cmd       (bk_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/deq_front.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue front end
// Accepts requests, decodes each into an operation and an end, and holds the
// result in a command register until the command queue takes it.
// ----------------------------------------------------------------------------
module deq_front import deq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  req_t  req,
  output logic  cmd_valid,
  input  logic  cmd_ready,
  output cmd_t  cmd
);

  cmd_t decoded;

  // Decode the request code into an operation and the end it works on.
  always_comb begin
    decoded.value   = DATA_WIDTH'(req.value);
    decoded.at_back = 1'b0;
    case (req.req_type)
      REQ_PUSH_FRONT: decoded.op = OP_PUSH;
      REQ_PUSH_BACK: begin
        decoded.op      = OP_PUSH;
        decoded.at_back = 1'b1;
      end
      REQ_POP_FRONT: decoded.op = OP_POP;
      REQ_POP_BACK: begin
        decoded.op      = OP_POP;
        decoded.at_back = 1'b1;
      end
      REQ_PEEK_FRONT: decoded.op = OP_PEEK;
      REQ_PEEK_BACK: begin
        decoded.op      = OP_PEEK;
        decoded.at_back = 1'b1;
      end
      REQ_CLEAR: decoded.op = OP_CLEAR;
      default:   decoded.op = OP_NOP;
    endcase
  end

  // The command register is free when empty or when its command moves on.
  assign req_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_ready) begin
      cmd_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= decoded;
    end
  end

endmodule

// ===== rtl/deq_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue command FIFO
// A two-entry queue of decoded commands between the front end and the back
// end, so that either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module deq_cmd_fifo import deq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  cmd_t  wr_cmd,
  output logic  rd_valid,
  input  logic  rd_ready,
  output cmd_t  rd_cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_cmd   = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 2'd1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

// ===== rtl/deq_back.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue back end
// Carries out decoded commands on a ring buffer with a front index and a
// count, and drives the registered response.
// ----------------------------------------------------------------------------
module deq_back import deq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_ready,
  input  cmd_t  cmd,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  output rsp_t  rsp
);

  localparam int SUM_W = CNT_W + 1;

  back_state_t           state;
  back_state_t           state_next;
  logic [IDX_W-1:0]      front_index;
  logic [IDX_W-1:0]      front_index_next;
  logic [CNT_W-1:0]      held_count;
  logic [CNT_W-1:0]      held_count_next;
  logic [CNT_W-1:0]      pend_count;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic                  mem_we;

  logic                  rsp_free;
  logic                  go;
  logic                  is_full;
  logic                  is_none;
  logic                  need_read;
  logic [STATUS_W-1:0]   status;
  logic [IDX_W-1:0]      front_dec;
  logic [IDX_W-1:0]      front_inc;
  logic [IDX_W-1:0]      back_free;
  logic [IDX_W-1:0]      back_last;

  // Ring index front + offset, folded once into the buffer range.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offset);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign rsp_free = !rsp_valid || rsp_ready;
  assign go       = (state == BK_EXEC) && cmd_valid && rsp_free;
  assign is_full  = (held_count == CNT_W'(CAPACITY));
  assign is_none  = (held_count == '0);

  // Neighbor slots of the two ends.
  assign front_dec = (front_index == '0) ? IDX_W'(CAPACITY - 1) : front_index - 1'b1;
  assign front_inc = (front_index == IDX_W'(CAPACITY - 1)) ? '0 : front_index + 1'b1;
  assign back_free = ring_add(front_index, held_count);
  assign back_last = ring_add(front_index, held_count - 1'b1);

  // Command execution: state update, slot write and slot read select.
  always_comb begin
    front_index_next = front_index;
    held_count_next  = held_count;
    status           = ST_OK;
    need_read        = 1'b0;
    mem_we           = 1'b0;
    wr_addr          = back_free;
    rd_addr          = cmd.at_back ? back_last : front_index;
    if (go) begin
      case (cmd.op)
        OP_PUSH: begin
          if (is_full) begin
            status = ST_FULL;
          end else begin
            mem_we          = 1'b1;
            held_count_next = held_count + 1'b1;
            if (!cmd.at_back) begin
              wr_addr          = front_dec;
              front_index_next = front_dec;
            end
          end
        end
        OP_POP, OP_PEEK: begin
          if (is_none) begin
            status = ST_EMPTY;
          end else begin
            need_read = 1'b1;
            if (cmd.op == OP_POP) begin
              held_count_next = held_count - 1'b1;
              if (!cmd.at_back) begin
                front_index_next = front_inc;
              end
            end
          end
        end
        OP_CLEAR: begin
          front_index_next = '0;
          held_count_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Next state: a read waits in BK_READ for the registered slot data.
  always_comb begin
    case (state)
      BK_EXEC: state_next = (go && need_read) ? BK_READ : BK_EXEC;
      BK_READ: state_next = BK_EXEC;
      default: state_next = BK_EXEC;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    case (state)
      BK_EXEC: cmd_ready = go;
      default: cmd_ready = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_EXEC;
      front_index <= '0;
      held_count  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      front_index <= front_index_next;
      held_count  <= held_count_next;
      if (state == BK_READ) begin
        rsp_valid <= 1'b1;
      end else if (go) begin
        rsp_valid <= !need_read;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload and the count held over a slot read.
  always_ff @(posedge clk) begin
    if (go) begin
      pend_count   <= held_count_next;
      rsp.element  <= '0;
      rsp.status   <= status;
      rsp.count    <= COUNT_W'(held_count_next);
      rsp.is_empty <= (held_count_next == '0);
    end else if (state == BK_READ) begin
      rsp.element  <= widen(rd_data);
      rsp.status   <= ST_OK;
      rsp.count    <= COUNT_W'(pend_count);
      rsp.is_empty <= (pend_count == '0);
    end
  end

  // Slot memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= cmd.value;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== dv/tb_double_ended_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop, peek, clear and unused requests into the deque and
// predicts every response from a ring-buffer copy of the deque kept here.
// Covers the empty and full errors, value extremes, ring wrap-around and a
// long response hold-off that backs the block up into its request channel.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;
  import deq_pkg::*;

  // The request code that the block decodes to no operation.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned RANDOM_BLOCKS  = 12;
  localparam int unsigned BLOCK_ITEMS    = 100;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Idle controls for the sender (req_gaps_on) and the receiver (rsp_stalls_on, rsp_hold).
  bit req_gaps_on   = 1'b1;
  bit rsp_stalls_on = 1'b1;
  bit rsp_hold      = 1'b0;

  // Deque contents as this side expects them.
  logic [DATA_WIDTH-1:0] slot_mem [CAPACITY];
  int unsigned head_idx;
  int unsigned fill_cnt;

  rsp_t        expected_rsps [$];
  rsp_t        want_rsp;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  double_ended_queue_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Apply one request to the local deque and return the response it causes.
  function automatic rsp_t deq_predict(input req_t item);
    rsp_t        o;
    int unsigned rd_idx;
    o = '0;
    case (item.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill_cnt >= CAPACITY) begin
          o.status = ST_FULL;
        end else if (item.req_type == REQ_PUSH_FRONT) begin
          head_idx = (head_idx + CAPACITY - 1) % CAPACITY;
          slot_mem[IDX_W'(head_idx)] = DATA_WIDTH'(item.value);
          fill_cnt++;
        end else begin
          slot_mem[IDX_W'((head_idx + fill_cnt) % CAPACITY)] = DATA_WIDTH'(item.value);
          fill_cnt++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (fill_cnt == 0) begin
          o.status = ST_EMPTY;
        end else begin
          if (item.req_type == REQ_POP_FRONT || item.req_type == REQ_PEEK_FRONT)
            rd_idx = head_idx;
          else
            rd_idx = (head_idx + fill_cnt - 1) % CAPACITY;
          o.element = ELEM_W'($signed(slot_mem[IDX_W'(rd_idx)]));
          if (item.req_type == REQ_POP_FRONT) begin
            head_idx = (head_idx + 1) % CAPACITY;
            fill_cnt--;
          end else if (item.req_type == REQ_POP_BACK) begin
            fill_cnt--;
          end
        end
      end
      REQ_CLEAR: begin
        head_idx = 0;
        fill_cnt = 0;
      end
      default: begin
      end
    endcase
    o.count    = COUNT_W'(fill_cnt);
    o.is_empty = (fill_cnt == 0);
    return o;
  endfunction

  // Offer one request after a random gap and record its expected response
  // once the transfer happens.
  task automatic send_req(input logic [REQ_W-1:0] code, input logic [ELEM_W-1:0] val);
    int unsigned gap;
    req_t        item;
    item.req_type = code;
    item.value    = val;
    gap = req_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_ready !== 1'b1);
    expected_rsps.push_back(deq_predict(item));
  endtask

  // Element values lean on the signed extremes now and then.
  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Random request with the given push and pop shares, in percent.
  task automatic send_random(input int unsigned push_pct, input int unsigned pop_pct);
    int unsigned roll;
    roll = $urandom_range(0, 199);
    if (roll >= 199)
      send_req(REQ_UNUSED, $urandom());
    else if (roll == 198)
      send_req(REQ_CLEAR, $urandom());
    else if (roll < 2 * push_pct)
      send_req($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
    else if (roll < 2 * (push_pct + pop_pct))
      send_req($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT, $urandom());
    else
      send_req($urandom_range(0, 1) ? REQ_PEEK_BACK : REQ_PEEK_FRONT, $urandom());
  endtask

  // Every read and every error on an empty deque, plus clear and the
  // unused code while nothing is held.
  task automatic test_empty_requests();
    send_req(REQ_POP_FRONT, 32'h1234_5678);
    send_req(REQ_POP_BACK, '0);
    send_req(REQ_PEEK_FRONT, '1);
    send_req(REQ_PEEK_BACK, 32'h8000_0000);
    send_req(REQ_UNUSED, 32'h7FFF_FFFF);
    send_req(REQ_CLEAR, 32'hDEAD_BEEF);
  endtask

  // Value extremes pushed at both ends and read back from both ends.
  task automatic test_value_extremes();
    send_req(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    send_req(REQ_PUSH_FRONT, 32'h8000_0000);
    send_req(REQ_PUSH_BACK, '1);
    send_req(REQ_PUSH_FRONT, '0);
    send_req(REQ_PEEK_FRONT, '0);
    send_req(REQ_PEEK_BACK, '0);
    send_req(REQ_UNUSED, 32'h5555_AAAA);
    send_req(REQ_POP_BACK, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_PEEK_BACK, '0);
    send_req(REQ_CLEAR, '1);
    send_req(REQ_PEEK_FRONT, '0);
  endtask

  // Fill to capacity from both ends, get refused at both ends, then read
  // and drain a little so the ring wraps.
  task automatic test_full_deque();
    int unsigned n;
    send_req(REQ_CLEAR, '0);
    for (n = 0; n < CAPACITY; n++)
      send_req((n % 2 == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
    send_req(REQ_PUSH_FRONT, 32'h0BAD_0BAD);
    send_req(REQ_PUSH_BACK, 32'h8000_0000);
    send_req(REQ_PEEK_FRONT, '0);
    send_req(REQ_PEEK_BACK, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    send_req(REQ_PUSH_FRONT, '1);
    send_req(REQ_POP_BACK, '0);
    send_req(REQ_PUSH_FRONT, 32'h1357_9BDF);
    send_req(REQ_PUSH_FRONT, '0);
  endtask

  // Hold the response side off for a long stretch while requests keep
  // coming back to back, so the block fills up and stalls its input.
  task automatic test_response_holdoff();
    int unsigned n;
    req_gaps_on = 1'b0;
    fork
      begin
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
      end
      begin
        for (n = 0; n < 48; n++)
          send_random(40, 30);
      end
    join
    req_gaps_on = 1'b1;
  endtask

  // Blocks of random traffic that grow, shrink or hold the fill level,
  // each with its own idle pattern on both sides.
  task automatic test_random_traffic();
    int unsigned blk;
    int unsigned n;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned idle_mode;
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case ($urandom_range(0, 2))
        0:       begin push_pct = 70; pop_pct = 20; end
        1:       begin push_pct = 20; pop_pct = 70; end
        default: begin push_pct = 42; pop_pct = 42; end
      endcase
      idle_mode     = $urandom_range(0, 3);
      req_gaps_on   = idle_mode[0];
      rsp_stalls_on = idle_mode[1];
      for (n = 0; n < BLOCK_ITEMS; n++)
        send_random(push_pct, pop_pct);
    end
    req_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
  endtask

  // Response side: a random wait before each transfer, longer while held.
  initial begin
    int unsigned wait_n;
    rsp_ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      wait_n = rsp_stalls_on ? $urandom_range(0, 8) : 0;
      if (wait_n > 0 || rsp_hold) begin
        rsp_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
        while (rsp_hold) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (rsp_valid !== 1'b1);
    end
  end

  // Compare each response transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
      if (expected_rsps.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
          $display("unexpected response: element %0d status %0d count %0d is_empty %0b",
                   rsp.element, rsp.status, rsp.count, rsp.is_empty);
      end else begin
        want_rsp = expected_rsps.pop_front();
        if (rsp.element !== want_rsp.element || rsp.status !== want_rsp.status ||
            rsp.count !== want_rsp.count || rsp.is_empty !== want_rsp.is_empty) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("mismatch at %0t: elem %0d/%0d st %0d/%0d cnt %0d/%0d empty %0b/%0b",
                     $realtime, want_rsp.element, rsp.element, want_rsp.status, rsp.status,
                     want_rsp.count, rsp.count, want_rsp.is_empty, rsp.is_empty);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_double_ended_queue_top: done, errors");
      $finish;
    end
  end

  initial begin
    cycle_cnt    = 0;
    mismatch_cnt = 0;
    head_idx     = 0;
    fill_cnt     = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_requests();
    test_value_extremes();
    test_full_deque();
    test_response_holdoff();
    test_random_traffic();
    req_valid <= 1'b0;

    // Drain the outstanding responses, then let the block settle.
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("tb_double_ended_queue_top: done, clean");
    else
      $display("tb_double_ended_queue_top: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/deq_pkg.sv
rtl/deq_front.sv
rtl/deq_cmd_fifo.sv
rtl/deq_back.sv
rtl/double_ended_queue_top.sv
dv/tb_double_ended_queue_top.sv
